FILE: design/pru_pkg.sv
// Shared constants, types and helper functions of the pixel replicating upscaler.
package pru_pkg;

   localparam int COORD_BITS  = 12;
   localparam int MAX_FACTOR  = 8;
   localparam int COLOUR_BITS = 16;

   localparam int FIELD_COORD_W  = 12;
   localparam int FIELD_COLOUR_W = 16;
   localparam int DIM_W          = 13;
   localparam int CSR_ADDR_W     = 4;
   localparam int CSR_DATA_W     = 32;

   localparam int PROD_W     = FIELD_COORD_W + DIM_W;
   localparam int REM_W      = DIM_W + 1;
   localparam int DIV_CNT_W  = $clog2(PROD_W);
   localparam int CNT_W      = $clog2(MAX_FACTOR + 1);
   localparam int MULT_W     = DIM_W + 3;

   typedef enum logic [1:0] {
      REG_SRC_WIDTH  = 2'd0,
      REG_SRC_HEIGHT = 2'd1,
      REG_DST_WIDTH  = 2'd2,
      REG_DST_HEIGHT = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [DIM_W-1:0] src_width;
      logic [DIM_W-1:0] src_height;
      logic [DIM_W-1:0] dst_width;
      logic [DIM_W-1:0] dst_height;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic last_copy;
   } status_type;

   // a zero dimension counts as one
   function automatic logic [DIM_W-1:0] at_least_one(input logic [DIM_W-1:0] v);
      return (v == '0) ? DIM_W'(1) : v;
   endfunction

   // ceil(d/s) clamped to 1..MAX_FACTOR, by comparing d against k*s
   function automatic logic [CNT_W-1:0] copy_count(input logic [DIM_W-1:0] d_reg,
                                                   input logic [DIM_W-1:0] s_reg);
      logic [MULT_W-1:0] d;
      logic [MULT_W-1:0] s;
      logic [MULT_W-1:0] prod;
      logic [CNT_W-1:0]  c;
      d = MULT_W'(at_least_one(d_reg));
      s = MULT_W'(at_least_one(s_reg));
      c = CNT_W'(MAX_FACTOR);
      for (int k = MAX_FACTOR - 1; k >= 1; k--) begin
         prod = MULT_W'(k) * s;
         if (prod >= d) begin
            c = CNT_W'(k);
         end
      end
      return c;
   endfunction

endpackage

FILE: design/pru_if.sv
// Valid/ready channel interfaces for source pixels and destination copies.
interface pru_req_if;
   import pru_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [FIELD_COORD_W-1:0]  src_x;
   logic [FIELD_COORD_W-1:0]  src_y;
   logic [FIELD_COLOUR_W-1:0] pixel_colour;

   modport source (output valid, output src_x, output src_y, output pixel_colour,
                   input ready);
   modport sink (input valid, input src_x, input src_y, input pixel_colour,
                 output ready);
endinterface

interface pru_rsp_if;
   import pru_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [FIELD_COORD_W-1:0]  dst_x;
   logic [FIELD_COORD_W-1:0]  dst_y;
   logic [FIELD_COLOUR_W-1:0] out_colour;
   logic                      last_copy;

   modport source (output valid, output dst_x, output dst_y, output out_colour,
                   output last_copy, input ready);
   modport sink (input valid, input dst_x, input dst_y, input out_colour,
                 input last_copy, output ready);
endinterface

FILE: design/pru_csr.sv
// APB-style configuration registers holding the image dimensions.
module pru_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pru_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pru_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pru_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output pru_pkg::cfg_type               cfg
);
   import pru_pkg::*;

   cfg_type          cfg_ff;
   logic             wr_en;
   reg_index_type    index;
   logic [DIM_W-1:0] wr_value;
   logic [DIM_W-1:0] rd_value;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign wr_value   = csr_pwdata[DIM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= DIM_W'(200);
         cfg_ff.src_height <= DIM_W'(150);
         cfg_ff.dst_width  <= DIM_W'(800);
         cfg_ff.dst_height <= DIM_W'(600);
      end else if (wr_en) begin
         case (index)
            REG_SRC_WIDTH:  cfg_ff.src_width  <= wr_value;
            REG_SRC_HEIGHT: cfg_ff.src_height <= wr_value;
            REG_DST_WIDTH:  cfg_ff.dst_width  <= wr_value;
            REG_DST_HEIGHT: cfg_ff.dst_height <= wr_value;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_SRC_WIDTH:  rd_value = cfg_ff.src_width;
         REG_SRC_HEIGHT: rd_value = cfg_ff.src_height;
         REG_DST_WIDTH:  rd_value = cfg_ff.dst_width;
         REG_DST_HEIGHT: rd_value = cfg_ff.dst_height;
         default:        rd_value = '0;
      endcase
   end

   assign csr_prdata = CSR_DATA_W'(rd_value);
   assign cfg        = cfg_ff;

endmodule

FILE: design/pru_div.sv
// Bit-serial restoring divider; keeps the low COORD_BITS of the quotient.
module pru_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pru_pkg::PROD_W-1:0]     dividend,
   input  logic [pru_pkg::DIM_W-1:0]      divisor,
   output logic                           busy,
   output logic [pru_pkg::COORD_BITS-1:0] quotient
);
   import pru_pkg::*;

   logic                  busy_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic [PROD_W-1:0]     dvd_ff;
   logic [DIM_W-1:0]      dsr_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [COORD_BITS-1:0] quo_ff;
   logic [REM_W-1:0]      rem_shift;
   logic                  fits;
   logic [REM_W-1:0]      rem_in;

   assign rem_shift = {rem_ff[REM_W-2:0], dvd_ff[PROD_W-1]};
   assign fits      = rem_shift >= REM_W'(dsr_ff);
   assign rem_in    = fits ? rem_shift - REM_W'(dsr_ff) : rem_shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= DIV_CNT_W'(PROD_W - 1);
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= at_least_one(divisor);
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[PROD_W-2:0], 1'b0};
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[COORD_BITS-2:0], fits};
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

FILE: design/pru_datapath.sv
// Datapath: origin dividers, copy counts, copy counters and result fields.
module pru_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  pru_pkg::cmd_type                   cmd,
   output pru_pkg::status_type                status,
   input  pru_pkg::cfg_type                   cfg,
   input  logic [pru_pkg::FIELD_COORD_W-1:0]  src_x,
   input  logic [pru_pkg::FIELD_COORD_W-1:0]  src_y,
   input  logic [pru_pkg::FIELD_COLOUR_W-1:0] pixel_colour,
   output logic [pru_pkg::FIELD_COORD_W-1:0]  dst_x,
   output logic [pru_pkg::FIELD_COORD_W-1:0]  dst_y,
   output logic [pru_pkg::FIELD_COLOUR_W-1:0] out_colour,
   output logic                               last_copy
);
   import pru_pkg::*;

   logic [CNT_W-1:0]       copy_col_ff;
   logic [CNT_W-1:0]       copy_row_ff;
   logic [CNT_W-1:0]       copies_across_ff;
   logic [CNT_W-1:0]       copies_down_ff;
   logic [COLOUR_BITS-1:0] held_colour_ff;
   logic [COORD_BITS-1:0]  base_col;
   logic [COORD_BITS-1:0]  base_row;
   logic                   busy_x;
   logic                   busy_y;
   logic [PROD_W-1:0]      prod_x;
   logic [PROD_W-1:0]      prod_y;
   logic                   col_end;
   logic                   row_end;
   logic [COORD_BITS-1:0]  col_sum;
   logic [COORD_BITS-1:0]  row_sum;

   assign prod_x = PROD_W'(src_x) * PROD_W'(at_least_one(cfg.dst_width));
   assign prod_y = PROD_W'(src_y) * PROD_W'(at_least_one(cfg.dst_height));

   pru_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.load),
      .dividend (prod_x),
      .divisor  (cfg.src_width),
      .busy     (busy_x),
      .quotient (base_col)
   );

   pru_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.load),
      .dividend (prod_y),
      .divisor  (cfg.src_height),
      .busy     (busy_y),
      .quotient (base_row)
   );

   assign col_end = (copy_col_ff + 1'b1) == copies_across_ff;
   assign row_end = (copy_row_ff + 1'b1) == copies_down_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         copy_col_ff      <= '0;
         copy_row_ff      <= '0;
         copies_across_ff <= CNT_W'(1);
         copies_down_ff   <= CNT_W'(1);
      end else if (cmd.load) begin
         copy_col_ff      <= '0;
         copy_row_ff      <= '0;
         copies_across_ff <= copy_count(cfg.dst_width, cfg.src_width);
         copies_down_ff   <= copy_count(cfg.dst_height, cfg.src_height);
      end else if (cmd.advance) begin
         if (col_end && row_end) begin
            copy_col_ff <= '0;
            copy_row_ff <= '0;
         end else if (col_end) begin
            copy_col_ff <= '0;
            copy_row_ff <= copy_row_ff + 1'b1;
         end else begin
            copy_col_ff <= copy_col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_colour_ff <= '0;
      end else if (cmd.load) begin
         held_colour_ff <= COLOUR_BITS'(pixel_colour);
      end
   end

   // destination coordinates wrap at COORD_BITS
   assign col_sum = base_col + COORD_BITS'(copy_col_ff);
   assign row_sum = base_row + COORD_BITS'(copy_row_ff);

   assign dst_x      = FIELD_COORD_W'(col_sum);
   assign dst_y      = FIELD_COORD_W'(row_sum);
   assign out_colour = FIELD_COLOUR_W'(held_colour_ff);
   assign last_copy  = col_end && row_end;

   assign status.div_busy  = busy_x || busy_y;
   assign status.last_copy = col_end && row_end;

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      copy_col_ff < copies_across_ff)
      else $error("copy column beyond copy count");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      copy_row_ff < copies_down_ff)
      else $error("copy row beyond copy count");

   a_dividers_together: assert property (@(posedge clock) disable iff (reset)
      busy_x == busy_y)
      else $error("origin dividers out of step");

endmodule

FILE: design/pru_ctrl.sv
// Controller: accepts a pixel, waits for the origin division, emits the copies.
module pru_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pru_pkg::cmd_type    cmd,
   input  pru_pkg::status_type status
);
   import pru_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      DIVIDE,
      EMIT
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   assign cmd.load    = req_valid && req_ready_ff;
   assign cmd.advance = rsp_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (cmd.load) begin
                  state_ff     <= DIVIDE;
                  req_ready_ff <= 1'b0;
               end else begin
                  req_ready_ff <= 1'b1;
               end
            end
            DIVIDE: begin
               if (!status.div_busy) begin
                  state_ff     <= EMIT;
                  rsp_valid_ff <= 1'b1;
               end
            end
            EMIT: begin
               if (cmd.advance && status.last_copy) begin
                  state_ff     <= IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= IDLE;
               req_ready_ff <= 1'b0;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   a_load_starts_div: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> status.div_busy)
      else $error("divider not started by accepted pixel");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready_ff && rsp_valid_ff))
      else $error("input open while copies pending");

   a_last_reopens: assert property (@(posedge clock) disable iff (reset)
      cmd.advance && status.last_copy |=> req_ready_ff && !rsp_valid_ff)
      else $error("input not reopened after final copy");

endmodule

FILE: design/pixel_replicating_upscaler.sv
// Top level of the pixel replicating upscaler.
//
// Usage: source pixels (src_x, src_y, pixel_colour) arrive on the req channel;
// for each one the block sends a block of copies on the rsp channel, row by
// row and left to right, with last_copy set on the final copy. The block is
// ceil(dst/src) copies on each axis, clamped to MAX_FACTOR, starting at
// floor(src*dst/src_dim). Dimensions are set through the csr APB port while
// the block is idle; a zero dimension counts as one.
// Timing: two bit-serial dividers work out the block origin of each taken
// pixel, one quotient bit per cycle over the PROD_W (25) bits of the dividend.
// The first copy is offered in the cycle after the dividers finish, and copies
// then leave at one per cycle while the receiver is ready. A new pixel is taken
// only after the last copy of the block has been accepted.
// When the receiver stalls the current copy holds on rsp and no new pixel is
// taken. Reset loads the default dimensions 200x150 to 800x600 and drops
// both valid and ready; req_ready rises the cycle after reset ends.
module pixel_replicating_upscaler (
   input  logic                           clock,
   input  logic                           reset,
   pru_req_if.sink                        req,
   pru_rsp_if.source                      rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pru_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pru_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pru_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import pru_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   pru_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .status    (status)
   );

   pru_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .cfg          (cfg),
      .src_x        (req.src_x),
      .src_y        (req.src_y),
      .pixel_colour (req.pixel_colour),
      .dst_x        (rsp.dst_x),
      .dst_y        (rsp.dst_y),
      .out_colour   (rsp.out_colour),
      .last_copy    (rsp.last_copy)
   );

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the pixel replicating upscaler: directed cases, then random traffic.
`timescale 1ns / 1ps

module tb_top;
   import pru_pkg::*;

   localparam int CYCLE_LIMIT      = 600000;
   localparam int DRAIN_CYCLES     = 40;
   localparam int RANDOM_PHASES    = 6;
   localparam int PIXELS_PER_PHASE = 20;
   localparam int N_DIRECTED       = 15;
   localparam int REPORT_LIMIT     = 10;

   typedef struct packed {
      logic [FIELD_COORD_W-1:0]  dst_x;
      logic [FIELD_COORD_W-1:0]  dst_y;
      logic [FIELD_COLOUR_W-1:0] colour;
      logic                      last;
   } copy_type;

   // one directed pixel; when reconfig is set the four dimensions are written first,
   // when typed is set the block origin and size are given here rather than computed
   typedef struct packed {
      logic                      reconfig;
      logic [DIM_W-1:0]          sw;
      logic [DIM_W-1:0]          sh;
      logic [DIM_W-1:0]          dw;
      logic [DIM_W-1:0]          dh;
      logic [FIELD_COORD_W-1:0]  x;
      logic [FIELD_COORD_W-1:0]  y;
      logic [FIELD_COLOUR_W-1:0] colour;
      logic                      typed;
      logic [FIELD_COORD_W-1:0]  col;
      logic [FIELD_COORD_W-1:0]  row;
      logic [3:0]                across;
      logic [3:0]                down;
   } pixel_case_type;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pru_req_if req_ch ();
   pru_rsp_if rsp_ch ();

   pixel_replicating_upscaler DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   pixel_case_type directed_cases [N_DIRECTED] = '{
      // default 200x150 -> 800x600, a 4x4 block
      '{0,    0,    0,    0,    0,    0,    0, 16'h0000, 1,    0,    0, 4, 4},
      '{0,    0,    0,    0,    0, 4095, 4095, 16'hFFFF, 1, 4092, 4092, 4, 4},
      '{0,    0,    0,    0,    0,  199,  149, 16'hA5A5, 1,  796,  596, 4, 4},
      // shrinking on both axes
      '{1,  800,  600,  200,  150,    3,    7, 16'h1234, 1,    0,    1, 1, 1},
      '{0,    0,    0,    0,    0, 4095, 4095, 16'h5A5A, 1, 1023, 1023, 1, 1},
      // all dimensions zero, read as one
      '{1,    0,    0,    0,    0,  123,  456, 16'hFFFF, 1,  123,  456, 1, 1},
      // ratio far above the clamp, origin wraps to zero
      '{1,    1,    1, 4096, 4096,    1,    2, 16'h0F0F, 1,    0,    0, 8, 8},
      '{0,    0,    0,    0,    0, 4095, 4095, 16'hF0F0, 1,    0,    0, 8, 8},
      // copies run past the top of the coordinate range
      '{1,    3,    3,   20,   20,  614,  614, 16'h8001, 1, 4093, 4093, 7, 7},
      '{1, 8191, 8191, 8191, 8191, 4095,    0, 16'h7FFE, 1, 4095,    0, 1, 1},
      '{1,    1, 8191, 8191,    1, 4095, 4095, 16'h0001, 0,    0,    0, 0, 0},
      '{1,    7,    5,    9,   11,    6,    4, 16'h3C3C, 0,    0,    0, 0, 0},
      // pixel outside the source image
      '{0,    0,    0,    0,    0,    7,    5, 16'hC3C3, 0,    0,    0, 0, 0},
      '{1, 4096, 4096, 4095, 4096, 4095, 4095, 16'h6666, 0,    0,    0, 0, 0},
      '{1,  200,  150,  800,  600,  100,   75, 16'h9999, 1,  400,  300, 4, 4}
   };

   logic [DIM_W-1:0] dim_reg [4];
   copy_type         pending_copies [$];
   bit               idle_on;
   int               hold_left;
   int               mismatches;
   int               cycles;
   int               pixels_sent;
   int               copies_seen;
   int               csr_writes;
   int               settings_used;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic longint unsigned dim_value(input logic [DIM_W-1:0] v);
      return (v == '0) ? 64'd1 : 64'(v);
   endfunction

   // ceil(d/s), clamped to MAX_FACTOR
   function automatic int unsigned copies_on_axis(input logic [DIM_W-1:0] d,
                                                  input logic [DIM_W-1:0] s);
      longint unsigned c;
      c = (dim_value(d) + dim_value(s) - 1) / dim_value(s);
      if (c > MAX_FACTOR) c = MAX_FACTOR;
      return int'(c);
   endfunction

   // floor(pos*d/s), wrapped to the coordinate width
   function automatic logic [FIELD_COORD_W-1:0] origin_on_axis(
         input logic [FIELD_COORD_W-1:0] pos,
         input logic [DIM_W-1:0] d, input logic [DIM_W-1:0] s);
      longint unsigned q;
      q = (64'(pos) * dim_value(d)) / dim_value(s);
      return FIELD_COORD_W'(q);
   endfunction

   function automatic void log_mismatch(input string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("tb: mismatch: %s", what);
   endfunction

   task automatic push_block(input logic [FIELD_COORD_W-1:0] col,
                             input logic [FIELD_COORD_W-1:0] row,
                             input int unsigned across, input int unsigned down,
                             input logic [FIELD_COLOUR_W-1:0] colour);
      copy_type cp;
      for (int r = 0; r < down; r++) begin
         for (int c = 0; c < across; c++) begin
            cp.dst_x  = col + FIELD_COORD_W'(c);
            cp.dst_y  = row + FIELD_COORD_W'(r);
            cp.colour = colour;
            cp.last   = (r == down - 1) && (c == across - 1);
            pending_copies.push_back(cp);
         end
      end
   endtask

   task automatic predict_block(input logic [FIELD_COORD_W-1:0] x,
                                input logic [FIELD_COORD_W-1:0] y,
                                input logic [FIELD_COLOUR_W-1:0] colour);
      push_block(origin_on_axis(x, dim_reg[REG_DST_WIDTH], dim_reg[REG_SRC_WIDTH]),
                 origin_on_axis(y, dim_reg[REG_DST_HEIGHT], dim_reg[REG_SRC_HEIGHT]),
                 copies_on_axis(dim_reg[REG_DST_WIDTH], dim_reg[REG_SRC_WIDTH]),
                 copies_on_axis(dim_reg[REG_DST_HEIGHT], dim_reg[REG_SRC_HEIGHT]),
                 colour);
   endtask

   // leaves valid high after the transfer so back-to-back pixels need no gap
   task automatic send_pixel(input logic [FIELD_COORD_W-1:0] x,
                             input logic [FIELD_COORD_W-1:0] y,
                             input logic [FIELD_COLOUR_W-1:0] colour);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.src_x        <= x;
      req_ch.src_y        <= y;
      req_ch.pixel_colour <= colour;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_copies.size() != 0);
   endtask

   // write one register, then read it back; psel stays up for the next access
   task automatic write_dim(input reg_index_type idx, input logic [DIM_W-1:0] value,
                            input logic [CSR_DATA_W-DIM_W-1:0] junk);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= {junk, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      dim_reg[idx] = value;
      csr_writes++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(value))
         log_mismatch($sformatf("%s read %h, expected %h", idx.name(), csr_prdata,
                                CSR_DATA_W'(value)));
   endtask

   task automatic set_dims(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                           input logic [DIM_W-1:0] dw, input logic [DIM_W-1:0] dh,
                           input bit dirty);
      write_dim(REG_SRC_WIDTH,  sw, dirty ? (CSR_DATA_W-DIM_W)'($urandom()) : '0);
      write_dim(REG_SRC_HEIGHT, sh, dirty ? (CSR_DATA_W-DIM_W)'($urandom()) : '0);
      write_dim(REG_DST_WIDTH,  dw, dirty ? (CSR_DATA_W-DIM_W)'($urandom()) : '0);
      write_dim(REG_DST_HEIGHT, dh, dirty ? (CSR_DATA_W-DIM_W)'($urandom()) : '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [DIM_W-1:0] random_src();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return DIM_W'($urandom_range(1, 16));
         default: return DIM_W'($urandom_range(1, 4096));
      endcase
   endfunction

   // mostly small upscale ratios, with some shrinking and some fully random sizes
   function automatic logic [DIM_W-1:0] random_dst(input logic [DIM_W-1:0] src);
      int unsigned s;
      int unsigned d;
      s = (src == '0) ? 1 : int'(src);
      case ($urandom_range(0, 5))
         0: d = $urandom_range(0, 8191);
         1: d = $urandom_range(1, s);
         default: d = s * $urandom_range(1, 5) - $urandom_range(0, s - 1);
      endcase
      if (d > 8191) d = 8191;
      return DIM_W'(d);
   endfunction

   function automatic logic [FIELD_COORD_W-1:0] random_coord(input logic [DIM_W-1:0] size);
      int unsigned bound;
      bound = (size == '0) ? 1 : ((size > 4096) ? 4096 : int'(size));
      if ($urandom_range(0, 4) == 0) return FIELD_COORD_W'($urandom_range(0, 4095));
      return FIELD_COORD_W'($urandom_range(0, bound - 1));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            copies_seen++;
            if (pending_copies.size() == 0) begin
               log_mismatch($sformatf("copy (%0d,%0d) %h last=%b with nothing pending",
                                      rsp_ch.dst_x, rsp_ch.dst_y, rsp_ch.out_colour,
                                      rsp_ch.last_copy));
            end else begin
               copy_type want;
               want = pending_copies.pop_front();
               if (rsp_ch.dst_x !== want.dst_x || rsp_ch.dst_y !== want.dst_y ||
                   rsp_ch.out_colour !== want.colour || rsp_ch.last_copy !== want.last)
                  log_mismatch($sformatf(
                     "got (%0d,%0d) %h last=%b, expected (%0d,%0d) %h last=%b",
                     rsp_ch.dst_x, rsp_ch.dst_y, rsp_ch.out_colour, rsp_ch.last_copy,
                     want.dst_x, want.dst_y, want.colour, want.last));
            end
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            hold_left <= $urandom_range(0, 11);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [DIM_W-1:0] sw;
      logic [DIM_W-1:0] sh;
      logic [FIELD_COORD_W-1:0] x;
      logic [FIELD_COORD_W-1:0] y;
      logic [FIELD_COLOUR_W-1:0] colour;

      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.src_x        <= '0;
      req_ch.src_y        <= '0;
      req_ch.pixel_colour <= '0;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      cycles              = 0;
      hold_left           = 0;
      mismatches          = 0;
      pixels_sent         = 0;
      copies_seen         = 0;
      csr_writes          = 0;
      settings_used       = 1;
      idle_on             = 1'b1;
      dim_reg[REG_SRC_WIDTH]  = 13'd200;
      dim_reg[REG_SRC_HEIGHT] = 13'd150;
      dim_reg[REG_DST_WIDTH]  = 13'd800;
      dim_reg[REG_DST_HEIGHT] = 13'd600;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_cases[i]) begin
         if (directed_cases[i].reconfig) begin
            wait_idle();
            set_dims(directed_cases[i].sw, directed_cases[i].sh,
                     directed_cases[i].dw, directed_cases[i].dh, 1'b0);
         end
         send_pixel(directed_cases[i].x, directed_cases[i].y, directed_cases[i].colour);
         if (directed_cases[i].typed)
            push_block(directed_cases[i].col, directed_cases[i].row,
                       directed_cases[i].across, directed_cases[i].down,
                       directed_cases[i].colour);
         else
            predict_block(directed_cases[i].x, directed_cases[i].y,
                          directed_cases[i].colour);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         // the closing phase runs at full throughput on both sides
         if (phase == RANDOM_PHASES - 1) idle_on = 1'b0;
         sw = random_src();
         sh = random_src();
         set_dims(sw, sh, random_dst(sw), random_dst(sh), $urandom_range(0, 1));
         for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
            x      = random_coord(dim_reg[REG_SRC_WIDTH]);
            y      = random_coord(dim_reg[REG_SRC_HEIGHT]);
            colour = FIELD_COLOUR_W'($urandom());
            send_pixel(x, y, colour);
            predict_block(x, y, colour);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d source pixels sent, %0d copies checked", pixels_sent, copies_seen);
      $display("tb: %0d register writes over %0d dimension settings, %0d mismatches",
               csr_writes, settings_used, mismatches);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
